@@ sv/fcc_pkg.sv @@
// Package for the frustum cull classifier: shared widths, codes and types.
// Used by every module of the block; it depends on nothing else.
`default_nettype none

package fcc_pkg;

    localparam int COEF_W         = 16;
    localparam int CFG_W          = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int PIU_W          = 3;
    localparam int RADIUS_W       = 15;
    localparam int NUM_CORNERS    = 8;
    localparam int DEF_MAX_PLANES = 6;
    localparam int DEF_COORD_BITS = 16;
    // Valid stages from the input register to the result register.
    localparam int NUM_STAGES     = 6;

    localparam logic [PIU_W-1:0] PLANES_RESET = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLANE_LEFT    = 3'd0,
        REG_PLANE_RIGHT   = 3'd1,
        REG_PLANE_BOTTOM  = 3'd2,
        REG_PLANE_TOP     = 3'd3,
        REG_PLANE_NEAR    = 3'd4,
        REG_PLANE_FAR     = 3'd5,
        REG_PLANES_IN_USE = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_POINT  = 2'd0,
        OP_SPHERE = 2'd1,
        OP_BOX    = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        CLS_OUTSIDE   = 2'd0,
        CLS_INTERSECT = 2'd1,
        CLS_INSIDE    = 2'd2
    } t_cls;

    // Coefficient a sits in the low bits, the offset d in the high bits.
    typedef struct packed {
        logic signed [COEF_W-1:0] d;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] a;
    } t_plane;

    // Per-plane test results; corner k takes max x when bit 0 of k is set,
    // max y for bit 1 and max z for bit 2. Corner 0 is the point or center.
    typedef struct packed {
        logic [NUM_CORNERS-1:0] neg;
        logic [NUM_CORNERS-1:0] zero;
        logic                   sph_out;
        logic                   sph_touch;
    } t_plane_flags;

endpackage

`default_nettype wire

@@ sv/fcc_plane_cfg.sv @@
// Configuration registers of the frustum cull classifier: planes and count.
// Depends on fcc_pkg.
`default_nettype none

module fcc_plane_cfg #(
    parameter int MAX_PLANES = fcc_pkg::DEF_MAX_PLANES
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [fcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [fcc_pkg::CFG_W-1:0]     i_cfg_wdata,
    output fcc_pkg::t_plane                    o_plane [MAX_PLANES],
    output logic [fcc_pkg::PIU_W-1:0]          o_planes_in_use
);

    fcc_pkg::t_plane                 r_plane [MAX_PLANES];
    logic [fcc_pkg::PIU_W-1:0]       r_planes_in_use;

    // Writes to plane slots beyond MAX_PLANES are dropped: those planes are
    // never tested.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < MAX_PLANES; p++) begin
                r_plane[p] <= '0;
            end
            r_planes_in_use <= fcc_pkg::PLANES_RESET;
        end else if (i_cfg_we) begin
            for (int p = 0; p < MAX_PLANES; p++) begin
                if (i_cfg_index == fcc_pkg::CFG_IDX_W'(p)) begin
                    r_plane[p] <= fcc_pkg::t_plane'(i_cfg_wdata);
                end
            end
            if (i_cfg_index == fcc_pkg::REG_PLANES_IN_USE) begin
                r_planes_in_use <= i_cfg_wdata[fcc_pkg::PIU_W-1:0];
            end
        end
    end

    assign o_plane         = r_plane;
    assign o_planes_in_use = r_planes_in_use;

endmodule

`default_nettype wire

@@ sv/fcc_plane_lane.sv @@
// One plane lane: products, two adder stages, then sign tests for all eight
// box corners and the radius test on corner 0. Depends on fcc_pkg.
`default_nettype none

module fcc_plane_lane #(
    parameter int COORD_BITS = fcc_pkg::DEF_COORD_BITS
) (
    input  wire logic                           i_clk,
    input  wire fcc_pkg::t_plane                i_plane,
    input  wire logic signed [COORD_BITS-1:0]   i_lo_x,
    input  wire logic signed [COORD_BITS-1:0]   i_lo_y,
    input  wire logic signed [COORD_BITS-1:0]   i_lo_z,
    input  wire logic signed [COORD_BITS-1:0]   i_hi_x,
    input  wire logic signed [COORD_BITS-1:0]   i_hi_y,
    input  wire logic signed [COORD_BITS-1:0]   i_hi_z,
    input  wire logic [fcc_pkg::RADIUS_W-1:0]   i_radius,
    output fcc_pkg::t_plane_flags               o_flags
);

    localparam int PROD_W = fcc_pkg::COEF_W + COORD_BITS;
    localparam int PART_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    logic signed [PROD_W-1:0] r_px [2];
    logic signed [PROD_W-1:0] r_py [2];
    logic signed [PROD_W-1:0] r_pz [2];
    logic signed [PART_W-1:0] r_sxy [4];
    logic signed [PART_W-1:0] r_szd [2];
    logic signed [SUM_W-1:0]  r_dist [fcc_pkg::NUM_CORNERS];
    fcc_pkg::t_plane_flags    r_flags;
    fcc_pkg::t_plane_flags    n_flags;
    logic signed [SUM_W-1:0]  rad_ext;

    // Stage 1: the six products of the coefficients with both box extents.
    always_ff @(posedge i_clk) begin
        r_px[0] <= PROD_W'(i_plane.a) * PROD_W'(i_lo_x);
        r_px[1] <= PROD_W'(i_plane.a) * PROD_W'(i_hi_x);
        r_py[0] <= PROD_W'(i_plane.b) * PROD_W'(i_lo_y);
        r_py[1] <= PROD_W'(i_plane.b) * PROD_W'(i_hi_y);
        r_pz[0] <= PROD_W'(i_plane.c) * PROD_W'(i_lo_z);
        r_pz[1] <= PROD_W'(i_plane.c) * PROD_W'(i_hi_z);
    end

    // Stage 2: x plus y for the four xy combinations, z plus offset for two.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_sxy[k] <= PART_W'(r_px[k % 2]) + PART_W'(r_py[k / 2]);
        end
        for (int j = 0; j < 2; j++) begin
            r_szd[j] <= PART_W'(r_pz[j]) + PART_W'(i_plane.d);
        end
    end

    // Stage 3: full signed distance of every corner, at full width.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < fcc_pkg::NUM_CORNERS; k++) begin
            r_dist[k] <= SUM_W'(r_sxy[k % 4]) + SUM_W'(r_szd[k / 4]);
        end
    end

    assign rad_ext = $signed(SUM_W'(i_radius));

    // Stage 4: a point on the plane counts as touching, not inside.
    always_comb begin
        n_flags = '0;
        for (int k = 0; k < fcc_pkg::NUM_CORNERS; k++) begin
            n_flags.neg[k]  = r_dist[k][SUM_W-1];
            n_flags.zero[k] = (r_dist[k] == '0);
        end
        n_flags.sph_out   = (r_dist[0] < -rad_ext);
        n_flags.sph_touch = (r_dist[0] <= rad_ext);
    end

    always_ff @(posedge i_clk) begin
        r_flags <= n_flags;
    end

    assign o_flags = r_flags;

endmodule

`default_nettype wire

@@ sv/fcc_classify.sv @@
// Final stage: folds the plane flags of the active planes into one
// classification per item. Depends on fcc_pkg.
`default_nettype none

module fcc_classify #(
    parameter int MAX_PLANES = fcc_pkg::DEF_MAX_PLANES
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire fcc_pkg::t_op              i_op,
    input  wire logic [fcc_pkg::PIU_W-1:0] i_planes_in_use,
    input  wire fcc_pkg::t_plane_flags     i_flags [MAX_PLANES],
    output logic                           o_valid,
    output fcc_pkg::t_cls                  o_class
);

    logic                              r_valid;
    fcc_pkg::t_cls                     r_class;
    fcc_pkg::t_cls                     n_class;
    fcc_pkg::t_cls                     corner_cls [fcc_pkg::NUM_CORNERS];
    logic [MAX_PLANES-1:0]             active;
    logic [fcc_pkg::NUM_CORNERS-1:0]   any_neg;
    logic [fcc_pkg::NUM_CORNERS-1:0]   any_zero;
    logic                              any_sph_out;
    logic                              any_sph_touch;
    logic                              corners_agree;

    // A count above MAX_PLANES simply enables every lane.
    always_comb begin
        for (int p = 0; p < MAX_PLANES; p++) begin
            active[p] = (fcc_pkg::PIU_W'(p) < i_planes_in_use);
        end
    end

    always_comb begin
        any_neg       = '0;
        any_zero      = '0;
        any_sph_out   = 1'b0;
        any_sph_touch = 1'b0;
        for (int p = 0; p < MAX_PLANES; p++) begin
            if (active[p]) begin
                any_neg       = any_neg | i_flags[p].neg;
                any_zero      = any_zero | i_flags[p].zero;
                any_sph_out   = any_sph_out | i_flags[p].sph_out;
                any_sph_touch = any_sph_touch | i_flags[p].sph_touch;
            end
        end
    end

    always_comb begin
        corners_agree = 1'b1;
        for (int k = 0; k < fcc_pkg::NUM_CORNERS; k++) begin
            if (any_neg[k]) begin
                corner_cls[k] = fcc_pkg::CLS_OUTSIDE;
            end else if (any_zero[k]) begin
                corner_cls[k] = fcc_pkg::CLS_INTERSECT;
            end else begin
                corner_cls[k] = fcc_pkg::CLS_INSIDE;
            end
        end
        for (int k = 1; k < fcc_pkg::NUM_CORNERS; k++) begin
            if (corner_cls[k] != corner_cls[0]) begin
                corners_agree = 1'b0;
            end
        end
    end

    always_comb begin
        case (i_op)
            fcc_pkg::OP_POINT: begin
                n_class = corner_cls[0];
            end
            fcc_pkg::OP_SPHERE: begin
                if (any_sph_out) begin
                    n_class = fcc_pkg::CLS_OUTSIDE;
                end else if (any_sph_touch) begin
                    n_class = fcc_pkg::CLS_INTERSECT;
                end else begin
                    n_class = fcc_pkg::CLS_INSIDE;
                end
            end
            fcc_pkg::OP_BOX: begin
                n_class = corners_agree ? corner_cls[0] : fcc_pkg::CLS_INTERSECT;
            end
            default: begin
                n_class = fcc_pkg::CLS_OUTSIDE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_class <= n_class;
    end

    assign o_valid = r_valid;
    assign o_class = r_class;

    // A box with no corner outside any active plane cannot be reported outside.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_op == fcc_pkg::OP_BOX && !(|any_neg))
        |=> (o_class != fcc_pkg::CLS_OUTSIDE))
        else $error("box with no outside corner classified outside");

endmodule

`default_nettype wire

@@ sv/frustum_cull_classifier_core.sv @@
// Top level of the frustum cull classifier: input register, plane lanes,
// classification stage and configuration registers. Depends on fcc_pkg,
// fcc_plane_cfg, fcc_plane_lane and fcc_classify.
//
//   Channel   Handshake                    Payload
//   -------   -------------------------    ------------------------------------
//   input     start (taken when !busy)     i_operation, i_pos_*, i_sphere_radius,
//                                          i_box_max_*
//   result    o_done (one-cycle strobe)    o_classification
//   config    i_cfg_we (no wait)           i_cfg_index, i_cfg_wdata
//
// One item is taken every cycle while busy is low; its result is strobed once
// it has passed the six register stages: input, multiply, two adder
// stages, plane test and classification.
// Reset clears the configuration to its defaults and empties the pipeline;
// busy is high only while reset is asserted.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module frustum_cull_classifier_core #(
    parameter int MAX_PLANES = fcc_pkg::DEF_MAX_PLANES,
    parameter int COORD_BITS = fcc_pkg::DEF_COORD_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     i_operation,
    input  wire logic signed [COORD_BITS-1:0]   i_pos_x,
    input  wire logic signed [COORD_BITS-1:0]   i_pos_y,
    input  wire logic signed [COORD_BITS-1:0]   i_pos_z,
    input  wire logic [fcc_pkg::RADIUS_W-1:0]   i_sphere_radius,
    input  wire logic signed [COORD_BITS-1:0]   i_box_max_x,
    input  wire logic signed [COORD_BITS-1:0]   i_box_max_y,
    input  wire logic signed [COORD_BITS-1:0]   i_box_max_z,
    output logic                                o_done,
    output logic [1:0]                          o_classification,
    input  wire logic                           i_cfg_we,
    input  wire logic [fcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fcc_pkg::CFG_W-1:0]      i_cfg_wdata
);

    localparam int SIDE_STAGES = fcc_pkg::NUM_STAGES - 1;

    logic                             accept;
    logic [SIDE_STAGES-1:0]           r_valid;
    fcc_pkg::t_op                     r_op [SIDE_STAGES];
    logic [fcc_pkg::RADIUS_W-1:0]     r_rad [4];
    logic signed [COORD_BITS-1:0]     r_lo_x, r_lo_y, r_lo_z;
    logic signed [COORD_BITS-1:0]     r_hi_x, r_hi_y, r_hi_z;
    fcc_pkg::t_plane                  plane [MAX_PLANES];
    logic [fcc_pkg::PIU_W-1:0]        planes_in_use;
    fcc_pkg::t_plane_flags            flags [MAX_PLANES];
    fcc_pkg::t_cls                    cls;

    assign busy   = !i_rst_n;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[SIDE_STAGES-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_op[0]  <= fcc_pkg::t_op'(i_operation);
        r_rad[0] <= i_sphere_radius;
        r_lo_x   <= i_pos_x;
        r_lo_y   <= i_pos_y;
        r_lo_z   <= i_pos_z;
        r_hi_x   <= i_box_max_x;
        r_hi_y   <= i_box_max_y;
        r_hi_z   <= i_box_max_z;
        for (int s = 1; s < SIDE_STAGES; s++) begin
            r_op[s] <= r_op[s-1];
        end
        for (int s = 1; s < 4; s++) begin
            r_rad[s] <= r_rad[s-1];
        end
    end

    fcc_plane_cfg #(
        .MAX_PLANES (MAX_PLANES)
    ) u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_plane         (plane),
        .o_planes_in_use (planes_in_use)
    );

    for (genvar p = 0; p < MAX_PLANES; p++) begin : g_lane
        fcc_plane_lane #(
            .COORD_BITS (COORD_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_plane  (plane[p]),
            .i_lo_x   (r_lo_x),
            .i_lo_y   (r_lo_y),
            .i_lo_z   (r_lo_z),
            .i_hi_x   (r_hi_x),
            .i_hi_y   (r_hi_y),
            .i_hi_z   (r_hi_z),
            .i_radius (r_rad[3]),
            .o_flags  (flags[p])
        );
    end

    fcc_classify #(
        .MAX_PLANES (MAX_PLANES)
    ) u_classify (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_valid[SIDE_STAGES-1]),
        .i_op            (r_op[SIDE_STAGES-1]),
        .i_planes_in_use (planes_in_use),
        .i_flags         (flags),
        .o_valid         (o_done),
        .o_class         (cls)
    );

    assign o_classification = cls;

    // Every accepted item produces exactly one result at the end of the pipeline.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(fcc_pkg::NUM_STAGES) o_done)
        else $error("accepted item produced no result");

    assert property (@(posedge i_clk)
        o_done |-> $past(accept, fcc_pkg::NUM_STAGES))
        else $error("result strobe without a matching transfer");

    // The unused operation code always reports outside.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_operation != fcc_pkg::OP_POINT
            && i_operation != fcc_pkg::OP_SPHERE
            && i_operation != fcc_pkg::OP_BOX)
        |-> ##(fcc_pkg::NUM_STAGES) (o_classification == fcc_pkg::CLS_OUTSIDE))
        else $error("unused operation not classified outside");

endmodule

`default_nettype wire

@@ sim/tb_frustum_cull_classifier_core.sv @@
// Testbench for frustum_cull_classifier_core: loads plane sets, streams points,
// spheres and boxes, and checks every classification against a local predictor.
// Depends on fcc_pkg and the RTL of the block.

module tb_frustum_cull_classifier_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW          = fcc_pkg::DEF_COORD_BITS;
    localparam int HALF_PERIOD = 5;

    // Codes the package does not name: the spare operation and register index.
    localparam logic [1:0]                    OP_UNUSED = 2'd3;
    localparam logic [fcc_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef enum int {
        PL_FRUSTUM,
        PL_SMALL,
        PL_FULL,
        PL_MIXED,
        PL_MIN,
        PL_MAX
    } t_plane_set;

    typedef struct {
        logic [1:0]                   op;
        logic signed [CW-1:0]         px;
        logic signed [CW-1:0]         py;
        logic signed [CW-1:0]         pz;
        logic [fcc_pkg::RADIUS_W-1:0] rad;
        logic signed [CW-1:0]         bx;
        logic signed [CW-1:0]         by;
        logic signed [CW-1:0]         bz;
    } t_shape;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [1:0]                    i_operation = '0;
    logic signed [CW-1:0]          i_pos_x = '0;
    logic signed [CW-1:0]          i_pos_y = '0;
    logic signed [CW-1:0]          i_pos_z = '0;
    logic [fcc_pkg::RADIUS_W-1:0]  i_sphere_radius = '0;
    logic signed [CW-1:0]          i_box_max_x = '0;
    logic signed [CW-1:0]          i_box_max_y = '0;
    logic signed [CW-1:0]          i_box_max_z = '0;
    logic                          o_done;
    logic [1:0]                    o_classification;
    logic                          i_cfg_we = 1'b0;
    logic [fcc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [fcc_pkg::CFG_W-1:0]     i_cfg_wdata = '0;

    // Predictor copy of the configuration registers.
    fcc_pkg::t_plane               plane_m [6];
    logic [fcc_pkg::PIU_W-1:0]     piu_m;

    fcc_pkg::t_cls                 cls_q [$];
    fcc_pkg::t_cls                 want_cls;
    int                            n_errors;
    int                            n_checked;
    int                            n_configs;
    int                            n_random_cfg;
    int                            send_idle_pct;
    int                            n_op [4];
    int                            n_cls [3];

    always #HALF_PERIOD i_clk = ~i_clk;

    frustum_cull_classifier_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_sphere_radius  (i_sphere_radius),
        .i_box_max_x      (i_box_max_x),
        .i_box_max_y      (i_box_max_y),
        .i_box_max_z      (i_box_max_z),
        .o_done           (o_done),
        .o_classification (o_classification),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    function automatic longint plane_distance(fcc_pkg::t_plane pl, longint x, longint y,
                                              longint z);
        return longint'(pl.a) * x + longint'(pl.b) * y + longint'(pl.c) * z
               + longint'(pl.d);
    endfunction

    function automatic int active_planes();
        int n;
        n = int'(piu_m);
        if (n > fcc_pkg::DEF_MAX_PLANES) n = fcc_pkg::DEF_MAX_PLANES;
        return n;
    endfunction

    // A point lying exactly on a plane counts as intersecting.
    function automatic fcc_pkg::t_cls point_class(longint x, longint y, longint z);
        int     n;
        bit     touch;
        longint d;
        n = active_planes();
        touch = 1'b0;
        for (int p = 0; p < n; p++) begin
            d = plane_distance(plane_m[p], x, y, z);
            if (d < 0) return fcc_pkg::CLS_OUTSIDE;
            if (d == 0) touch = 1'b1;
        end
        return touch ? fcc_pkg::CLS_INTERSECT : fcc_pkg::CLS_INSIDE;
    endfunction

    // Only an outside plane ends the sphere test early.
    function automatic fcc_pkg::t_cls sphere_class(longint x, longint y, longint z,
                                                   longint r);
        int     n;
        bit     touch;
        longint d;
        n = active_planes();
        touch = 1'b0;
        for (int p = 0; p < n; p++) begin
            d = plane_distance(plane_m[p], x, y, z);
            if (d < -r) return fcc_pkg::CLS_OUTSIDE;
            if (d <= r) touch = 1'b1;
        end
        return touch ? fcc_pkg::CLS_INTERSECT : fcc_pkg::CLS_INSIDE;
    endfunction

    // Corners are taken from min and max as given, even when min exceeds max.
    function automatic fcc_pkg::t_cls box_class(t_shape s);
        fcc_pkg::t_cls first;
        fcc_pkg::t_cls c;
        longint        x;
        longint        y;
        longint        z;
        first = fcc_pkg::CLS_OUTSIDE;
        for (int k = 0; k < fcc_pkg::NUM_CORNERS; k++) begin
            x = (k & 1) ? longint'(s.bx) : longint'(s.px);
            y = (k & 2) ? longint'(s.by) : longint'(s.py);
            z = (k & 4) ? longint'(s.bz) : longint'(s.pz);
            c = point_class(x, y, z);
            if (k == 0) first = c;
            else if (c != first) return fcc_pkg::CLS_INTERSECT;
        end
        return first;
    endfunction

    function automatic fcc_pkg::t_cls predict_class(t_shape s);
        case (s.op)
            fcc_pkg::OP_POINT:  return point_class(s.px, s.py, s.pz);
            fcc_pkg::OP_SPHERE: return sphere_class(s.px, s.py, s.pz, longint'(s.rad));
            fcc_pkg::OP_BOX:    return box_class(s);
            default:            return fcc_pkg::CLS_OUTSIDE;
        endcase
    endfunction

    function automatic t_shape make_shape(logic [1:0] op, int x, int y, int z, int r,
                                          int mx, int my, int mz);
        t_shape s;
        s.op  = op;
        s.px  = CW'(x);
        s.py  = CW'(y);
        s.pz  = CW'(z);
        s.rad = fcc_pkg::RADIUS_W'(r);
        s.bx  = CW'(mx);
        s.by  = CW'(my);
        s.bz  = CW'(mz);
        return s;
    endfunction

    function automatic fcc_pkg::t_plane make_plane(t_plane_set kind, int idx, int half);
        fcc_pkg::t_plane                   pl;
        t_plane_set                        k;
        logic signed [fcc_pkg::COEF_W-1:0] unit;
        k = kind;
        if (kind == PL_MIXED) k = t_plane_set'($urandom_range(PL_FRUSTUM, PL_FULL));
        pl = '0;
        case (k)
            PL_FRUSTUM: begin
                // Axis-aligned planes facing inward, each half units from the origin.
                unit = (idx % 2) ? -16'sd1 : 16'sd1;
                case (idx / 2)
                    0:       pl.a = unit;
                    1:       pl.b = unit;
                    default: pl.c = unit;
                endcase
                pl.d = fcc_pkg::COEF_W'(half);
            end
            PL_SMALL: begin
                pl.a = fcc_pkg::COEF_W'(int'($urandom_range(0, 6)) - 3);
                pl.b = fcc_pkg::COEF_W'(int'($urandom_range(0, 6)) - 3);
                pl.c = fcc_pkg::COEF_W'(int'($urandom_range(0, 6)) - 3);
                pl.d = fcc_pkg::COEF_W'(int'($urandom_range(0, 128)) - 64);
            end
            PL_MIN:  pl = {4{16'h8000}};
            PL_MAX:  pl = {4{16'h7FFF}};
            default: pl = {$urandom, $urandom};
        endcase
        return pl;
    endfunction

    function automatic logic signed [CW-1:0] pick_coord(int half);
        int v;
        case ($urandom_range(0, 9))
            0, 1:    v = int'($urandom_range(0, 65535)) - 32768;
            2:       v = half;
            3:       v = -half;
            default: v = int'($urandom_range(0, 2 * half + 6)) - half - 3;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[CW-1:0];
    endfunction

    function automatic t_shape random_shape(int half);
        t_shape               s;
        int                   roll;
        logic signed [CW-1:0] t;
        roll = int'($urandom_range(0, 19));
        if (roll < 7) s.op = fcc_pkg::OP_POINT;
        else if (roll < 13) s.op = fcc_pkg::OP_SPHERE;
        else if (roll < 19) s.op = fcc_pkg::OP_BOX;
        else s.op = OP_UNUSED;
        if ($urandom_range(0, 3) == 0) begin
            s.px  = CW'($urandom);
            s.py  = CW'($urandom);
            s.pz  = CW'($urandom);
            s.rad = fcc_pkg::RADIUS_W'($urandom);
            s.bx  = CW'($urandom);
            s.by  = CW'($urandom);
            s.bz  = CW'($urandom);
        end else begin
            s.px  = pick_coord(half);
            s.py  = pick_coord(half);
            s.pz  = pick_coord(half);
            s.rad = fcc_pkg::RADIUS_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                                   : $urandom_range(0, half));
            s.bx  = pick_coord(half);
            s.by  = pick_coord(half);
            s.bz  = pick_coord(half);
            // Most boxes are well ordered; the rest keep min and max as drawn.
            if ($urandom_range(0, 4) != 0) begin
                if (s.bx < s.px) begin t = s.bx; s.bx = s.px; s.px = t; end
                if (s.by < s.py) begin t = s.by; s.by = s.py; s.py = t; end
                if (s.bz < s.pz) begin t = s.bz; s.bz = s.pz; s.pz = t; end
            end
        end
        return s;
    endfunction

    task automatic report_mismatch(string what, logic [1:0] want, logic [1:0] got);
        n_errors++;
        $display("ERROR %0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic write_reg(logic [fcc_pkg::CFG_IDX_W-1:0] idx,
                             logic [fcc_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        if (idx < fcc_pkg::REG_PLANES_IN_USE) plane_m[idx] = fcc_pkg::t_plane'(data);
        else if (idx == fcc_pkg::REG_PLANES_IN_USE) piu_m = data[fcc_pkg::PIU_W-1:0];
    endtask

    task automatic load_config(t_plane_set kind, int half, logic [fcc_pkg::PIU_W-1:0] n);
        for (int i = 0; i < 6; i++)
            write_reg(fcc_pkg::CFG_IDX_W'(i), make_plane(kind, i, half));
        write_reg(fcc_pkg::REG_PLANES_IN_USE, fcc_pkg::CFG_W'(n));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_configs++;
    endtask

    task automatic send_shape(t_shape s);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        start           <= 1'b1;
        i_operation     <= s.op;
        i_pos_x         <= s.px;
        i_pos_y         <= s.py;
        i_pos_z         <= s.pz;
        i_sphere_radius <= s.rad;
        i_box_max_x     <= s.bx;
        i_box_max_y     <= s.by;
        i_box_max_z     <= s.bz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        cls_q.push_back(predict_class(s));
        n_op[s.op]++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic wait_idle();
        while (cls_q.size() != 0) @(posedge i_clk);
        repeat (fcc_pkg::NUM_STAGES + 2) @(posedge i_clk);
    endtask

    // With the reset planes every distance is zero, so points and spheres touch.
    task automatic test_reset_defaults();
        send_idle_pct = 0;
        send_shape(make_shape(fcc_pkg::OP_POINT, 0, 0, 0, 0, 0, 0, 0));
        send_shape(make_shape(fcc_pkg::OP_SPHERE, 1234, -77, 5, 0, 0, 0, 0));
        send_shape(make_shape(fcc_pkg::OP_BOX, -5, -5, -5, 0, 5, 5, 5));
        stop_sending();
        wait_idle();
    endtask

    task automatic test_directed();
        load_config(PL_FRUSTUM, 100, 3'd6);
        send_shape(make_shape(fcc_pkg::OP_POINT, 0, 0, 0, 0, 0, 0, 0));
        send_shape(make_shape(fcc_pkg::OP_POINT, 100, 0, 0, 0, 0, 0, 0));
        send_shape(make_shape(fcc_pkg::OP_POINT, 101, 0, 0, 0, 0, 0, 0));
        send_shape(make_shape(fcc_pkg::OP_POINT, 0, 0, -100, 0, 0, 0, 0));
        send_shape(make_shape(fcc_pkg::OP_SPHERE, 0, 0, 0, 0, 0, 0, 0));
        send_shape(make_shape(fcc_pkg::OP_SPHERE, 90, 0, 0, 10, 0, 0, 0));
        send_shape(make_shape(fcc_pkg::OP_SPHERE, 115, 0, 0, 15, 0, 0, 0));
        send_shape(make_shape(fcc_pkg::OP_SPHERE, 116, 0, 0, 15, 0, 0, 0));
        send_shape(make_shape(fcc_pkg::OP_BOX, -50, -50, -50, 0, 50, 50, 50));
        send_shape(make_shape(fcc_pkg::OP_BOX, -50, -50, -50, 0, 150, 50, 50));
        send_shape(make_shape(fcc_pkg::OP_BOX, 200, 200, 200, 0, 300, 300, 300));
        send_shape(make_shape(fcc_pkg::OP_BOX, 50, 50, 50, 0, -50, -50, -50));
        send_shape(make_shape(fcc_pkg::OP_BOX, 150, 0, 0, 0, -50, 0, 0));
        send_shape(make_shape(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0));
        stop_sending();
        wait_idle();

        // A write to the spare index must leave every register alone.
        write_reg(REG_SPARE, '1);
        load_config(PL_FRUSTUM, 100, 3'd0);
        send_shape(make_shape(fcc_pkg::OP_POINT, 32767, 32767, 32767, 0, 0, 0, 0));
        send_shape(make_shape(fcc_pkg::OP_BOX, -32768, -32768, -32768, 32767,
                              32767, 32767, 32767));
        stop_sending();
        wait_idle();

        // Seven planes in use saturates to six.
        load_config(PL_FRUSTUM, 100, 3'd7);
        send_shape(make_shape(fcc_pkg::OP_POINT, 100, 100, 100, 0, 0, 0, 0));
        stop_sending();
        wait_idle();

        load_config(PL_MIN, 0, 3'd6);
        send_shape(make_shape(fcc_pkg::OP_POINT, -32768, -32768, -32768, 0, 0, 0, 0));
        send_shape(make_shape(fcc_pkg::OP_SPHERE, 32767, 32767, 32767, 32767, 0, 0, 0));
        stop_sending();
        wait_idle();

        load_config(PL_MAX, 0, 3'd6);
        send_shape(make_shape(fcc_pkg::OP_BOX, -32768, -32768, -32768, 0,
                              32767, 32767, 32767));
        stop_sending();
        wait_idle();
    endtask

    task automatic test_random_stream(int idle_pct, int batches, int per_batch);
        t_plane_set                kind;
        int                        half;
        logic [fcc_pkg::PIU_W-1:0] n;
        send_idle_pct = idle_pct;
        for (int b = 0; b < batches; b++) begin
            wait_idle();
            kind = t_plane_set'($urandom_range(PL_FRUSTUM, PL_MIXED));
            half = ($urandom_range(0, 4) == 0) ? int'($urandom_range(10000, 32000))
                                               : int'($urandom_range(1, 300));
            // The first settings sweep every plane count, later ones are random.
            if (n_random_cfg < 8) n = fcc_pkg::PIU_W'((n_random_cfg * 5 + 6) % 8);
            else if ($urandom_range(0, 7) == 0) n = fcc_pkg::PIU_W'($urandom);
            else n = fcc_pkg::PIU_W'($urandom_range(1, fcc_pkg::DEF_MAX_PLANES));
            n_random_cfg++;
            load_config(kind, half, n);
            for (int i = 0; i < per_batch; i++)
                send_shape(random_shape(half));
            stop_sending();
        end
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (cls_q.size() == 0) begin
                report_mismatch("result with nothing pending", 2'bxx, o_classification);
            end else begin
                want_cls = cls_q.pop_front();
                n_checked++;
                if (o_classification !== want_cls)
                    report_mismatch("classification", want_cls, o_classification);
                else
                    n_cls[want_cls]++;
            end
        end
    end

    initial begin
        for (int i = 0; i < 6; i++) plane_m[i] = '0;
        piu_m = fcc_pkg::PLANES_RESET;
        n_errors = 0;
        n_checked = 0;
        n_configs = 0;
        n_random_cfg = 0;
        send_idle_pct = 0;
        for (int i = 0; i < 4; i++) n_op[i] = 0;
        for (int i = 0; i < 3; i++) n_cls[i] = 0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_directed();
        test_random_stream(31, 6, 30);
        test_random_stream(58, 6, 30);
        test_random_stream(0, 6, 30);
        wait_idle();

        $display("Checked %0d results (%0d points, %0d spheres, %0d boxes, %0d spare) %s",
                 n_checked, n_op[fcc_pkg::OP_POINT], n_op[fcc_pkg::OP_SPHERE],
                 n_op[fcc_pkg::OP_BOX], n_op[OP_UNUSED],
                 $sformatf("over %0d plane settings.", n_configs));
        $display("Correct outcomes seen: %0d outside, %0d intersecting, %0d inside.",
                 n_cls[fcc_pkg::CLS_OUTSIDE], n_cls[fcc_pkg::CLS_INTERSECT],
                 n_cls[fcc_pkg::CLS_INSIDE]);
        if (n_errors == 0 && cls_q.size() == 0)
            $display("frustum_cull_classifier_core: match");
        else
            $display("frustum_cull_classifier_core: mismatch");
        $finish;
    end

    initial begin
        #2ms;
        $display("Timeout with %0d results still pending.", cls_q.size());
        $display("frustum_cull_classifier_core: mismatch");
        $finish;
    end

endmodule
